// ===== sv/dmdpr_pkg.sv =====
// Shared constants for the dual-mode deadband proportional regulator.
package dmdpr_pkg;

	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOW_GAIN          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLOW_THRESHOLD     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD      = 3'd4;

	localparam logic [15:0] UPDATE_PERIOD_RST = 16'd10;
	localparam logic [15:0] FEED_SCALE        = 16'd20000;

	localparam logic [1:0] MODE_OFF      = 2'd0;
	localparam logic [1:0] MODE_PRESSURE = 2'd1;
	localparam logic [1:0] MODE_FLOW     = 2'd2;

	typedef logic [2:0] seq_state_t;

endpackage

// ===== sv/dual_mode_deadband_p_regulator.sv =====
// Dual-mode deadband proportional regulator, top level.
//
// Channel  | Dir | Transaction carries
// s_axis   | in  | one refresh tick: flags, target, pressure and flow samples
// m_axis   | out | one result per tick: feed command, stop, mode, running
// cfg      | in  | register write: gains, thresholds, update period
//
// A tick without an update goes from accept to ST_DONE, where the result loads;
// an update inside the deadband first passes ST_DIFF and ST_CMP (difference,
// deadband compare); one outside it also ST_MUL0 to ST_MUL3 (four passes of the
// shared 33x16 multiplier, saturation). One tick is in flight at a time; ready returns as the result loads.
// arst_n clears control state and the configuration registers to their reset values.
// A result waiting on m_axis_tready does not block the next accept.
module dual_mode_deadband_p_regulator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// work_enable, quit_request, set_pressure, set_flow, target_value,
	// stall_detected, motor_moving, present_pressure, present_flow, zero pad
	input  logic [dmdpr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// feed_valid, feed_distance, stop_motor, active_mode, is_running, zero pad
	output logic [dmdpr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                                 cfg_wen,
	input  logic [dmdpr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dmdpr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import dmdpr_pkg::*;

	localparam seq_state_t ST_IDLE = 3'd0;
	localparam seq_state_t ST_DIFF = 3'd1;
	localparam seq_state_t ST_CMP  = 3'd2;
	localparam seq_state_t ST_MUL0 = 3'd3;
	localparam seq_state_t ST_MUL1 = 3'd4;
	localparam seq_state_t ST_MUL2 = 3'd5;
	localparam seq_state_t ST_MUL3 = 3'd6;
	localparam seq_state_t ST_DONE = 3'd7;

	// input fields
	logic        in_work, in_quit, in_set_p, in_set_f, in_stall, in_moving;
	logic [31:0] in_target, in_pres, in_flow;

	assign in_work   = s_axis_tdata[0];
	assign in_quit   = s_axis_tdata[1];
	assign in_set_p  = s_axis_tdata[2];
	assign in_set_f  = s_axis_tdata[3];
	assign in_target = s_axis_tdata[35:4];
	assign in_stall  = s_axis_tdata[36];
	assign in_moving = s_axis_tdata[37];
	assign in_pres   = s_axis_tdata[69:38];
	assign in_flow   = s_axis_tdata[101:70];

	// configuration
	logic [31:0] p_gain_q, f_gain_q;
	logic [30:0] p_thr_q, f_thr_q;
	logic [15:0] period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_q <= '0;
			f_gain_q <= '0;
			p_thr_q  <= '0;
			f_thr_q  <= '0;
			period_q <= UPDATE_PERIOD_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_PRESSURE_GAIN:      p_gain_q <= cfg_data;
				REG_FLOW_GAIN:          f_gain_q <= cfg_data;
				REG_PRESSURE_THRESHOLD: p_thr_q  <= cfg_data[30:0];
				REG_FLOW_THRESHOLD:     f_thr_q  <= cfg_data[30:0];
				REG_UPDATE_PERIOD:      period_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// control state
	seq_state_t  state_q;
	logic        running_q;
	logic [1:0]  mode_q;
	logic [31:0] target_q;
	logic [15:0] tick_q;

	// per-tick working registers
	logic [31:0] op_present_q, op_gain_q;
	logic [30:0] op_thr_q;
	logic        upd_q, feed_q, neg_q;
	logic        res_stop_q, res_run_q;
	logic [1:0]  res_mode_q;
	logic [32:0] diff_q, mag_d_q;
	logic [15:0] gain_lo_q, gain_hi_q;
	logic [63:0] acc_q;
	logic [47:0] q_q;

	// output register
	logic        out_valid_q;
	logic [36:0] out_data_q;

	logic accept;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// tick decision
	logic        nx_running, nx_stop, nx_upd;
	logic [1:0]  nx_mode, set_mode;
	logic [31:0] nx_target;
	logic [15:0] nx_tick, tick_inc;

	always_comb begin
		nx_running = running_q;
		nx_mode    = mode_q;
		nx_target  = target_q;
		nx_tick    = tick_q;
		nx_stop    = 1'b0;
		nx_upd     = 1'b0;
		set_mode   = mode_q;
		tick_inc   = tick_q + 16'd1;
		if (!running_q) begin
			nx_running = in_work;
		end else if (!in_work) begin
			nx_running = 1'b0;
			nx_mode    = MODE_OFF;
			nx_target  = '0;
			nx_tick    = '0;
		end else if (in_quit) begin
			nx_mode = MODE_OFF;
			nx_stop = 1'b1;
		end else begin
			if (in_set_p || in_set_f) begin
				nx_target = in_target;
			end
			if (in_set_f) begin
				set_mode = MODE_FLOW;
			end else if (in_set_p) begin
				set_mode = MODE_PRESSURE;
			end
			nx_mode = in_stall ? MODE_OFF : set_mode;
			if (nx_mode == MODE_OFF) begin
				nx_tick = '0;
			end else if (tick_inc >= period_q) begin
				nx_tick = '0;
				nx_upd  = !in_moving;
			end else begin
				nx_tick = tick_inc;
			end
		end
	end

	// shared 33x16 multiplier
	logic [32:0] mul_a;
	logic [15:0] mul_b;
	logic [48:0] mul_p;

	always_comb begin
		mul_a = mag_d_q;
		mul_b = gain_lo_q;
		case (state_q)
			ST_MUL1: mul_b = gain_hi_q;
			ST_MUL2: begin
				mul_a = {1'b0, acc_q[63:32]};
				mul_b = FEED_SCALE;
			end
			ST_MUL3: begin
				mul_a = {1'b0, acc_q[31:0]};
				mul_b = FEED_SCALE;
			end
			default: ;
		endcase
		mul_p = {16'd0, mul_a} * {33'd0, mul_b};
	end

	// deadband compare and gain magnitude
	logic [32:0] mag_d;
	logic [31:0] mag_g;
	assign mag_d = diff_q[32] ? (33'd0 - diff_q) : diff_q;
	assign mag_g = op_gain_q[31] ? (32'd0 - op_gain_q) : op_gain_q;

	// saturation
	logic [31:0] sat_dist;
	always_comb begin
		if (neg_q) begin
			sat_dist = (q_q >= 48'h0000_8000_0000) ? 32'h8000_0000 : (32'd0 - q_q[31:0]);
		end else begin
			sat_dist = (q_q > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q_q[31:0];
		end
	end

	logic done_fire;
	assign done_fire = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			running_q   <= 1'b0;
			mode_q      <= MODE_OFF;
			target_q    <= '0;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						running_q <= nx_running;
						mode_q    <= nx_mode;
						target_q  <= nx_target;
						tick_q    <= nx_tick;
						state_q   <= nx_upd ? ST_DIFF : ST_DONE;
					end
				end
				ST_DIFF: state_q <= ST_CMP;
				ST_CMP:  state_q <= (mag_d >= {2'b00, op_thr_q}) ? ST_MUL0 : ST_DONE;
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_DONE;
				ST_DONE: begin
					if (done_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_present_q <= (nx_mode == MODE_FLOW) ? in_flow : in_pres;
			op_gain_q    <= (nx_mode == MODE_FLOW) ? f_gain_q : p_gain_q;
			op_thr_q     <= (nx_mode == MODE_FLOW) ? f_thr_q : p_thr_q;
			upd_q        <= nx_upd;
			feed_q       <= 1'b0;
			res_stop_q   <= nx_stop;
			res_mode_q   <= nx_mode;
			res_run_q    <= nx_running;
		end
		if (state_q == ST_DIFF) begin
			diff_q <= {target_q[31], target_q} - {op_present_q[31], op_present_q};
		end
		if (state_q == ST_CMP) begin
			mag_d_q   <= mag_d;
			gain_lo_q <= mag_g[15:0];
			gain_hi_q <= mag_g[31:16];
			neg_q     <= diff_q[32] ^ op_gain_q[31];
			feed_q    <= upd_q && (mag_d >= {2'b00, op_thr_q});
		end
		if (state_q == ST_MUL0) begin
			acc_q <= {15'd0, mul_p};
		end
		if (state_q == ST_MUL1) begin
			acc_q <= acc_q + {mul_p[47:0], 16'd0};
		end
		if (state_q == ST_MUL2) begin
			q_q <= mul_p[47:0];
		end
		if (state_q == ST_MUL3) begin
			q_q <= q_q + {31'd0, mul_p[48:32]};
		end
		if (done_fire) begin
			out_data_q <= {res_run_q, res_mode_q, res_stop_q,
				(feed_q ? sat_dist : 32'd0), feed_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, out_data_q};

endmodule

// ===== sv/dmdpr_checker.sv =====
// Port-level checker for the regulator, bound to the top level.
module dmdpr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [dmdpr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import dmdpr_pkg::*;

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output payload changed while stalled");

	// one tick in flight: ready drops right after an accept
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accepted a second tick while busy");

	a_feed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == 32'd0)
		else $error("nonzero distance without feed_valid");

	a_feed_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |->
			m_axis_tdata[36] && !m_axis_tdata[33] && m_axis_tdata[35:34] != MODE_OFF)
		else $error("feed issued outside an active mode");

	a_stop_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[33] || !m_axis_tdata[36]) |->
			m_axis_tdata[35:34] == MODE_OFF)
		else $error("mode left active after stop or shutdown");

endmodule

bind dual_mode_deadband_p_regulator dmdpr_checker u_dmdpr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
